@@ src/swrm_pkg.sv @@
// shared types and constants for the stack with running minimum
package swrm_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DEPTH       = 128;
  localparam int COUNT_OUT_W = 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    FN_PUSH = 1'b0,
    FN_POP  = 1'b1
  } func_t;

  typedef struct packed {
    func_t                         func;
    logic signed [VALUE_WIDTH-1:0] push_value;
  } in_t;

  typedef struct packed {
    status_t                       status;
    logic signed [VALUE_WIDTH-1:0] top_value;
    logic signed [VALUE_WIDTH-1:0] min_value;
    logic [COUNT_OUT_W-1:0]        entry_count;
    logic                          is_empty;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_load;
  } dp_stat_t;

endpackage

@@ src/swrm_ctrl.sv @@
// controller state machine: handshakes and sequencing of the pop reload
module swrm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  swrm_pkg::dp_stat_t   stat,
  output swrm_pkg::ctrl_cmd_t  cmd
);

  swrm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swrm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swrm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.pop_load ? swrm_pkg::S_LOAD : swrm_pkg::S_OUT;
        end
      end
      swrm_pkg::S_LOAD: begin
        state_nxt = swrm_pkg::S_OUT;
      end
      swrm_pkg::S_OUT: begin
        if (out_ready) begin
          if (in_valid) begin
            state_nxt = stat.pop_load ? swrm_pkg::S_LOAD : swrm_pkg::S_OUT;
          end else begin
            state_nxt = swrm_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = swrm_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state_r == swrm_pkg::S_IDLE) ||
                 ((state_r == swrm_pkg::S_OUT) && out_ready);
    out_valid  = (state_r == swrm_pkg::S_OUT);
    cmd.accept = in_valid && in_ready;
    cmd.load   = (state_r == swrm_pkg::S_LOAD);
  end

endmodule

@@ src/swrm_dp.sv @@
// datapath: entry memory, top-of-stack registers, count and result fields
module swrm_dp #(
  parameter int DEPTH = swrm_pkg::DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swrm_pkg::ctrl_cmd_t  cmd,
  input  swrm_pkg::in_t        in_data,
  output swrm_pkg::dp_stat_t   stat,
  output swrm_pkg::out_t       out_data
);

  localparam int VW = swrm_pkg::VALUE_WIDTH;
  localparam int OW = swrm_pkg::COUNT_OUT_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // each entry holds {running minimum, value}
  logic [2*VW-1:0] mem [DEPTH];
  logic [2*VW-1:0] rd_data_r;

  logic [CW-1:0]          count_r, count_nxt;
  logic signed [VW-1:0]   top_r;
  logic signed [VW-1:0]   min_r;
  swrm_pkg::status_t      status_r, status_nxt;

  logic                   is_zero, is_full;
  logic                   is_push, is_pop;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic signed [VW-1:0]   new_min;
  logic [CW+OW-1:0]       cnt_ext;

  always_comb begin
    is_zero = (count_r == '0);
    is_full = (count_r == CW'(DEPTH));
    is_push = (in_data.func == swrm_pkg::FN_PUSH);
    is_pop  = (in_data.func == swrm_pkg::FN_POP);
    new_min = (is_zero || (in_data.push_value < min_r)) ? in_data.push_value : min_r;

    // a pop leaving at least one entry must fetch the new top from memory
    stat.pop_load = is_pop && (count_r >= CW'(2));

    wr_en   = cmd.accept && is_push && !is_full;
    rd_en   = cmd.accept && stat.pop_load;
    wr_addr = count_r[AW-1:0];
    rd_addr = AW'(count_r - CW'(2));

    count_nxt  = count_r;
    status_nxt = status_r;
    if (cmd.accept) begin
      status_nxt = swrm_pkg::ST_OK;
      if (is_push) begin
        if (is_full) begin
          status_nxt = swrm_pkg::ST_OVERFLOW;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end else begin
        if (is_zero) begin
          status_nxt = swrm_pkg::ST_UNDERFLOW;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {new_min, in_data.push_value};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (wr_en) begin
      top_r <= in_data.push_value;
      min_r <= new_min;
    end else if (cmd.load) begin
      {min_r, top_r} <= rd_data_r;
    end
  end

  always_comb begin
    cnt_ext              = {{OW{1'b0}}, count_r};
    out_data.status      = status_r;
    out_data.top_value   = is_zero ? '0 : top_r;
    out_data.min_value   = is_zero ? '0 : min_r;
    out_data.entry_count = cnt_ext[OW-1:0];
    out_data.is_empty    = is_zero;
  end

endmodule

@@ src/stack_with_running_minimum.sv @@
// top level: bounded stack of signed values with running minimum
//
// Input channel in_valid/in_ready/in_data carries one operation per transfer:
// a push of in_data.push_value or a pop of the top entry. Every operation
// gives exactly one result on out_valid/out_ready/out_data: status (ok,
// overflow, underflow), the new top, the new minimum, the entry count and an
// empty flag. Top and minimum read 0 while the stack is empty. A rejected
// operation leaves the stack unchanged.
// Timing: a push or a pop that empties the stack shows its result in the cycle
// after the input transfer; a pop that leaves entries passes through S_LOAD
// first, since the new top is read from the entry memory and registered
// before it is loaded into the top registers. Throughput: one operation per
// cycle for pushes while out_ready is high; such pops take no input while in
// S_LOAD; the next input is taken in the same cycle the result is transferred.
// The result is held in registers while out_ready is low and no new input is
// taken until it leaves. Reset clears the count and the state machine; the
// memory needs no clearing since only entries below the count are read.
module stack_with_running_minimum #(
  parameter int DEPTH = swrm_pkg::DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  swrm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output swrm_pkg::out_t  out_data
);

  swrm_pkg::ctrl_cmd_t cmd;
  swrm_pkg::dp_stat_t  stat;

  swrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swrm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

  // overflow only happens with a full stack
  a_ovf_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == swrm_pkg::ST_OVERFLOW) |-> !out_data.is_empty)
    else $error("overflow reported on empty stack");

  // underflow only happens with an empty stack
  a_udf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == swrm_pkg::ST_UNDERFLOW) |-> out_data.is_empty)
    else $error("underflow reported on non-empty stack");

  // running minimum never exceeds the top
  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_empty |-> (out_data.min_value <= out_data.top_value))
    else $error("minimum above top value");

  // no new transfer while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while result stalled");

endmodule
